FILE: rtl/core/hcv_pkg.sv
// Shared types and constants for the fixed-radius circle Hough voting block.
// Used by hcv_ctrl, hcv_datapath and hough_circle_vote_fixed_radius.
package hcv_pkg;

   localparam int PIX_W      = 8;   // request row / column
   localparam int RADIUS_W   = 7;
   localparam int THRESH_W   = 16;
   localparam int DIM_W      = 9;   // image_rows / image_cols
   localparam int VOTES_W    = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int COORD_W    = 10;  // signed center coordinate, pixel +/- radius
   localparam int STEP_W     = 9;   // signed midpoint x / y
   localparam int ERR_W      = 12;  // signed midpoint error term

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_ROWS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_COLS = 2'd3;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET    = 7'd64;
   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 16'd97;
   localparam logic [DIM_W-1:0]    DIM_RESET       = 9'd256;

   localparam logic KIND_VOTE = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_READ
   } state_type;

   typedef struct packed {
      logic load;        // capture request and start a new item
      logic clear_step;  // zero one store entry of the sweep
      logic walk_step;   // issue one circle point
      logic read_issue;  // issue the read-and-clear of one cell
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;  // sweep is at the final entry
      logic walk_done;   // midpoint walk has finished (x < y)
   } dp_status_type;

endpackage

FILE: rtl/core/hcv_ctrl.sv
// Controller state machine of the circle Hough voting block.
// Depends on hcv_pkg; drives hcv_datapath through ctrl_cmd_type.
module hcv_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  req_kind,
   input  hcv_pkg::dp_status_type status,
   output logic                  busy,
   output hcv_pkg::ctrl_cmd_type cmd
);
   import hcv_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = (req_kind == KIND_READ) ? ST_READ : ST_WALK;
         end
         ST_WALK: begin
            if (status.walk_done) state_in = ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      busy = 1'b1;
      cmd  = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_WALK: begin
            cmd.walk_step = ~status.walk_done;
         end
         ST_READ: begin
            cmd.read_issue = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

FILE: rtl/core/hcv_datapath.sv
// Datapath of the circle Hough voting block: midpoint walker, vote store with
// read-modify-write pipeline, clearing sweep and result register. Depends on hcv_pkg.
module hcv_datapath #(
   parameter int MAX_ROWS    = 256,
   parameter int MAX_COLS    = 256,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [hcv_pkg::RADIUS_W-1:0]    radius,
   input  logic [hcv_pkg::THRESH_W-1:0]    vote_threshold,
   input  logic [hcv_pkg::DIM_W-1:0]       image_rows,
   input  logic [hcv_pkg::DIM_W-1:0]       image_cols,
   input  logic [hcv_pkg::PIX_W-1:0]       pix_row,
   input  logic [hcv_pkg::PIX_W-1:0]       pix_col,
   input  hcv_pkg::ctrl_cmd_type           cmd,
   output hcv_pkg::dp_status_type          status,
   output logic                            rsp_strobe,
   output logic [hcv_pkg::VOTES_W-1:0]     rsp_votes,
   output logic                            rsp_is_center
);
   import hcv_pkg::*;

   localparam int DEPTH   = MAX_ROWS * MAX_COLS;
   localparam int AW      = $clog2(DEPTH);
   localparam int LR_W    = $clog2(MAX_ROWS + 1);
   localparam int LC_W    = $clog2(MAX_COLS + 1);
   localparam int LM_W    = (LR_W > LC_W) ? LR_W : LC_W;
   localparam int LIM_W   = (LM_W > DIM_W + 1) ? LM_W : DIM_W + 1;
   localparam int CMP_W   = (COUNT_WIDTH > VOTES_W) ? COUNT_WIDTH : VOTES_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [LIM_W-1:0] ROWS_MAX = LIM_W'(MAX_ROWS);
   localparam logic [LIM_W-1:0] COLS_MAX = LIM_W'(MAX_COLS);
   localparam logic [AW-1:0]    ROW_PITCH = AW'(MAX_COLS);
   localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);

   logic [COUNT_WIDTH-1:0] mem [DEPTH];

   // item registers
   logic [PIX_W-1:0]         pr_ff, pr_in, pc_ff, pc_in;
   logic signed [STEP_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ERR_W-1:0]  e_ff, e_in;
   logic [2:0]               pt_ff, pt_in;
   logic [LIM_W-1:0]         lim_r_ff, lim_r_in, lim_c_ff, lim_c_in;
   logic [AW-1:0]            clr_addr_ff, clr_addr_in;

   // read-modify-write pipeline
   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_clr_ff, s1_clr_in;
   logic                     s1_rsp_ff, s1_rsp_in;
   logic [AW-1:0]            s1_addr_ff, s1_addr_in;
   logic [COUNT_WIDTH-1:0]   rd_data_ff;
   logic                     wb_valid_ff, wb_valid_in;
   logic [AW-1:0]            wb_addr_ff, wb_addr_in;
   logic [COUNT_WIDTH-1:0]   wb_data_ff, wb_data_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   logic [VOTES_W-1:0]       rsp_votes_ff, rsp_votes_in;
   logic                     rsp_is_center_ff, rsp_is_center_in;

   logic signed [COORD_W-1:0] xs, ys, pr_s, pc_s, dr, dc, pt_r, pt_c;
   logic                      pt_inb, pt_last, in_store;
   logic [AW-1:0]             pt_addr, pix_addr, rd_addr;
   logic signed [STEP_W-1:0]  y_next, x_next;
   logic signed [ERR_W-1:0]   e_mid, e_next;
   logic                      x_dec;
   logic [COUNT_WIDTH-1:0]    cur, upd, rsp_count;
   logic [CMP_W-1:0]          cnt_ext;
   logic                      mem_we;
   logic [AW-1:0]             mem_waddr;
   logic [COUNT_WIDTH-1:0]    mem_wdata;

   // pick one of the eight symmetric points
   always_comb begin
      xs   = COORD_W'(x_ff);
      ys   = COORD_W'(y_ff);
      pr_s = $signed({2'b00, pr_ff});
      pc_s = $signed({2'b00, pc_ff});
      case (pt_ff)
         3'd0:    begin dr =  xs; dc =  ys; end
         3'd1:    begin dr = -xs; dc =  ys; end
         3'd2:    begin dr =  ys; dc =  xs; end
         3'd3:    begin dr =  ys; dc = -xs; end
         3'd4:    begin dr = -ys; dc =  xs; end
         3'd5:    begin dr = -ys; dc = -xs; end
         3'd6:    begin dr =  xs; dc = -ys; end
         default: begin dr = -xs; dc = -ys; end
      endcase
      pt_r = pr_s + dr;
      pt_c = pc_s + dc;
      pt_inb = ~pt_r[COORD_W-1] && ~pt_c[COORD_W-1]
               && (LIM_W'(pt_r[COORD_W-2:0]) < lim_r_ff)
               && (LIM_W'(pt_c[COORD_W-2:0]) < lim_c_ff);
      pt_addr  = AW'(pt_r[COORD_W-2:0]) * ROW_PITCH + AW'(pt_c[COORD_W-2:0]);
      pix_addr = AW'(pr_ff) * ROW_PITCH + AW'(pc_ff);
      in_store = (LIM_W'(pr_ff) < ROWS_MAX) && (LIM_W'(pc_ff) < COLS_MAX);
      pt_last  = (pt_ff == 3'd7) || ((pt_ff == 3'd3) && (y_ff == '0));
      rd_addr  = cmd.read_issue ? pix_addr : pt_addr;
   end

   // midpoint step
   always_comb begin
      y_next = y_ff + STEP_W'(1);
      e_mid  = e_ff + ERR_W'(1) + (ERR_W'(y_next) <<< 1);
      x_dec  = (e_mid - ERR_W'(x_ff)) >= 0;
      x_next = x_dec ? (x_ff - STEP_W'(1)) : x_ff;
      e_next = x_dec ? (e_mid + ERR_W'(1) - (ERR_W'(x_next) <<< 1)) : e_mid;
   end

   always_comb begin
      pr_in    = pr_ff;
      pc_in    = pc_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      e_in     = e_ff;
      pt_in    = pt_ff;
      lim_r_in = lim_r_ff;
      lim_c_in = lim_c_ff;
      if (cmd.load) begin
         pr_in    = pix_row;
         pc_in    = pix_col;
         x_in     = STEP_W'(radius);
         y_in     = '0;
         e_in     = '0;
         pt_in    = '0;
         lim_r_in = (LIM_W'(image_rows) < ROWS_MAX) ? LIM_W'(image_rows) : ROWS_MAX;
         lim_c_in = (LIM_W'(image_cols) < COLS_MAX) ? LIM_W'(image_cols) : COLS_MAX;
      end else if (cmd.walk_step) begin
         if (pt_last) begin
            pt_in = '0;
            x_in  = x_next;
            y_in  = y_next;
            e_in  = e_next;
         end else begin
            pt_in = pt_ff + 3'd1;
         end
      end
   end

   always_comb begin
      clr_addr_in = cmd.clear_step ? clr_addr_ff + AW'(1) : clr_addr_ff;
      s1_valid_in = (cmd.walk_step && pt_inb) || (cmd.read_issue && in_store);
      s1_clr_in   = cmd.read_issue;
      s1_rsp_in   = cmd.read_issue;
      s1_addr_in  = rd_addr;
   end

   // stage 1: forward the write of the previous cycle, which the read missed
   always_comb begin
      cur = (wb_valid_ff && (wb_addr_ff == s1_addr_ff)) ? wb_data_ff : rd_data_ff;
      if (s1_clr_ff) begin
         upd = '0;
      end else if (cur == COUNT_MAX) begin
         upd = cur;
      end else begin
         upd = cur + COUNT_WIDTH'(1);
      end
      mem_we      = cmd.clear_step || s1_valid_ff;
      mem_waddr   = cmd.clear_step ? clr_addr_ff : s1_addr_ff;
      mem_wdata   = cmd.clear_step ? '0 : upd;
      wb_valid_in = s1_valid_ff;
      wb_addr_in  = s1_addr_ff;
      wb_data_in  = upd;
      rsp_count   = s1_valid_ff ? cur : '0;
      cnt_ext     = CMP_W'(rsp_count);
      rsp_strobe_in    = s1_rsp_ff;
      rsp_votes_in     = (cnt_ext > CMP_W'({VOTES_W{1'b1}})) ? {VOTES_W{1'b1}}
                                                             : cnt_ext[VOTES_W-1:0];
      rsp_is_center_in = cnt_ext >= CMP_W'(vote_threshold);
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         s1_rsp_ff     <= 1'b0;
         wb_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         clr_addr_ff   <= clr_addr_in;
         s1_valid_ff   <= s1_valid_in;
         s1_rsp_ff     <= s1_rsp_in;
         wb_valid_ff   <= wb_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pr_ff            <= pr_in;
      pc_ff            <= pc_in;
      x_ff             <= x_in;
      y_ff             <= y_in;
      e_ff             <= e_in;
      pt_ff            <= pt_in;
      lim_r_ff         <= lim_r_in;
      lim_c_ff         <= lim_c_in;
      s1_clr_ff        <= s1_clr_in;
      s1_addr_ff       <= s1_addr_in;
      wb_addr_ff       <= wb_addr_in;
      wb_data_ff       <= wb_data_in;
      rsp_votes_ff     <= rsp_votes_in;
      rsp_is_center_ff <= rsp_is_center_in;
   end

   assign status.clear_last = (clr_addr_ff == LAST_ADDR);
   assign status.walk_done  = (x_ff < y_ff);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_votes         = rsp_votes_ff;
   assign rsp_is_center     = rsp_is_center_ff;

endmodule

FILE: rtl/core/hough_circle_vote_fixed_radius.sv
// Top level of the fixed-radius circle Hough voting block: register file,
// controller and datapath. Depends on hcv_pkg, hcv_ctrl and hcv_datapath.
//
// Request channel: a request (req_kind, req_row, req_col) is taken at a rising
// edge with start high and busy low. A vote request walks the midpoint circle
// of the configured radius around the pixel and, for each in-bounds point,
// adds one to its center cell, saturating. A read request returns the
// cell's count and threshold flag, then clears the cell.
// Result channel: rsp_strobe is high for one cycle with rsp_votes and
// rsp_is_center; it rises once the read has passed the READ state, stage 1
// and the result register. The receiver cannot stall; a result is never held.
// Timing: the walk steps to one circle point per cycle and updates each
// in-bounds cell through a pipelined read-modify-write port. A read keeps
// busy high for one cycle.
// Reset: the CSR registers return to their defaults and a clearing pass zeroes the
// store, one entry per cycle, with busy high. CSR writes are taken at any
// time but belong in idle periods.
module hough_circle_vote_fixed_radius #(
   parameter int MAX_ROWS    = 256,
   parameter int MAX_COLS    = 256,
   parameter int COUNT_WIDTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_kind,
   input  logic [hcv_pkg::PIX_W-1:0]         req_row,
   input  logic [hcv_pkg::PIX_W-1:0]         req_col,
   output logic                              rsp_strobe,
   output logic [hcv_pkg::VOTES_W-1:0]       rsp_votes,
   output logic                              rsp_is_center,
   input  logic                              csr_we,
   input  logic [hcv_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hcv_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import hcv_pkg::*;

   logic [RADIUS_W-1:0] radius_ff, radius_in;
   logic [THRESH_W-1:0] threshold_ff, threshold_in;
   logic [DIM_W-1:0]    rows_ff, rows_in;
   logic [DIM_W-1:0]    cols_ff, cols_in;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   always_comb begin
      radius_in    = radius_ff;
      threshold_in = threshold_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_RADIUS:     radius_in    = csr_wdata[RADIUS_W-1:0];
            CSR_THRESHOLD:  threshold_in = csr_wdata[THRESH_W-1:0];
            CSR_IMAGE_ROWS: rows_in      = csr_wdata[DIM_W-1:0];
            CSR_IMAGE_COLS: cols_in      = csr_wdata[DIM_W-1:0];
            default:        radius_in    = radius_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= RADIUS_RESET;
         threshold_ff <= THRESHOLD_RESET;
         rows_ff      <= DIM_RESET;
         cols_ff      <= DIM_RESET;
      end else begin
         radius_ff    <= radius_in;
         threshold_ff <= threshold_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
      end
   end

   hcv_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   hcv_datapath #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLS    (MAX_COLS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .radius         (radius_ff),
      .vote_threshold (threshold_ff),
      .image_rows     (rows_ff),
      .image_cols     (cols_ff),
      .pix_row        (req_row),
      .pix_col        (req_col),
      .cmd            (cmd),
      .status         (status),
      .rsp_strobe     (rsp_strobe),
      .rsp_votes      (rsp_votes),
      .rsp_is_center  (rsp_is_center)
   );

endmodule

FILE: verif/hough_circle_vote_fixed_radius_tb.sv
// Testbench for hough_circle_vote_fixed_radius: directed and random vote/read
// requests checked against a scoreboard that keeps its own copy of the vote store.
// Depends on hcv_pkg and the hough_circle_vote_fixed_radius RTL.
module hough_circle_vote_fixed_radius_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hcv_pkg::*;

   localparam int GRID          = 256;
   localparam int CYCLE_LIMIT   = 3_000_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int BURST_VOTES   = 64;

   class vote_scoreboard;
      typedef struct {
         logic [VOTES_W-1:0] votes;
         logic               is_center;
      } read_result_type;

      bit [VOTES_W-1:0]  cell_votes [GRID*GRID];
      bit [RADIUS_W-1:0] radius;
      bit [THRESH_W-1:0] threshold;
      bit [DIM_W-1:0]    rows;
      bit [DIM_W-1:0]    cols;
      read_result_type   pending_reads [$];
      int                failures;

      function new();
         radius    = RADIUS_RESET;
         threshold = THRESHOLD_RESET;
         rows      = DIM_RESET;
         cols      = DIM_RESET;
         failures  = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_RADIUS:     radius    = data[RADIUS_W-1:0];
            CSR_THRESHOLD:  threshold = data[THRESH_W-1:0];
            CSR_IMAGE_ROWS: rows      = data[DIM_W-1:0];
            CSR_IMAGE_COLS: cols      = data[DIM_W-1:0];
            default: ;
         endcase
      endfunction

      function void bump(int r, int c, int lim_r, int lim_c);
         if (r >= 0 && r < lim_r && c >= 0 && c < lim_c) begin
            if (cell_votes[r*GRID + c] != '1)
               cell_votes[r*GRID + c] = cell_votes[r*GRID + c] + 1'b1;
         end
      endfunction

      function void note_request(logic kind, logic [PIX_W-1:0] row, logic [PIX_W-1:0] col);
         int              lim_r;
         int              lim_c;
         int              pr;
         int              pc;
         int              x;
         int              y;
         int              e;
         int              idx;
         read_result_type res;
         pr = int'(row);
         pc = int'(col);
         if (kind == KIND_VOTE) begin
            lim_r = (int'(rows) < GRID) ? int'(rows) : GRID;
            lim_c = (int'(cols) < GRID) ? int'(cols) : GRID;
            x = int'(radius);
            y = 0;
            e = 0;
            // midpoint walk; the x == y point is counted by both octants
            while (x >= y) begin
               bump(pr + x, pc + y, lim_r, lim_c);
               bump(pr - x, pc + y, lim_r, lim_c);
               bump(pr + y, pc + x, lim_r, lim_c);
               bump(pr + y, pc - x, lim_r, lim_c);
               if (y != 0) begin
                  bump(pr - y, pc + x, lim_r, lim_c);
                  bump(pr - y, pc - x, lim_r, lim_c);
                  bump(pr + x, pc - y, lim_r, lim_c);
                  bump(pr - x, pc - y, lim_r, lim_c);
               end
               y = y + 1;
               e = e + 1 + 2 * y;
               if (2 * (e - x) + 1 > 0) begin
                  x = x - 1;
                  e = e + 1 - 2 * x;
               end
            end
         end else begin
            idx = pr * GRID + pc;
            res.votes     = cell_votes[idx];
            res.is_center = (cell_votes[idx] >= threshold);
            cell_votes[idx] = '0;
            pending_reads.insert(pending_reads.size(), res);
         end
      endfunction

      function void check_read(logic [VOTES_W-1:0] votes, logic is_center);
         read_result_type want;
         if (pending_reads.size() == 0) begin
            $error("result with no read request outstanding: votes %0d is_center %0b",
                   votes, is_center);
            failures++;
            return;
         end
         want = pending_reads.pop_front();
         if (votes !== want.votes) begin
            $error("votes: expected %0d, got %0d", want.votes, votes);
            failures++;
         end
         if (is_center !== want.is_center) begin
            $error("is_center: expected %0b, got %0b", want.is_center, is_center);
            failures++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_kind = KIND_VOTE;
   logic [PIX_W-1:0]      req_row = '0;
   logic [PIX_W-1:0]      req_col = '0;
   logic                  rsp_strobe;
   logic [VOTES_W-1:0]    rsp_votes;
   logic                  rsp_is_center;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_RADIUS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   vote_scoreboard sb = new();
   bit             idle_on = 1'b1;

   hough_circle_vote_fixed_radius dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_kind      (req_kind),
      .req_row       (req_row),
      .req_col       (req_col),
      .rsp_strobe    (rsp_strobe),
      .rsp_votes     (rsp_votes),
      .rsp_is_center (rsp_is_center),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sample everything at the rising edge, before the block updates
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_strobe !== 1'b0)
            sb.check_read(rsp_votes, rsp_is_center);
         if (csr_we === 1'b1)
            sb.write_reg(csr_index, csr_wdata);
         if (start === 1'b1 && busy === 1'b0)
            sb.note_request(req_kind, req_row, req_col);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("hough_circle_vote_fixed_radius verification failed");
      $finish;
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(logic kind, logic [PIX_W-1:0] row, logic [PIX_W-1:0] col);
      if (idle_on && $urandom_range(99) < 28) begin
         start = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      start    = 1'b1;
      req_kind = kind;
      req_row  = row;
      req_col  = col;
      forever begin
         @(posedge clock);
         if (busy === 1'b0) break;
      end
      @(negedge clock);
   endtask

   // drop start, wait for every read result and for the walk to finish
   task automatic settle();
      start = 1'b0;
      forever begin
         @(posedge clock);
         if (sb.pending_reads.size() == 0 && busy === 1'b0) break;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, int value);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = CSR_DATA_W'(value);
      @(negedge clock);
   endtask

   task automatic configure(int r, int thr, int rows, int cols);
      settle();
      write_csr(CSR_RADIUS, r);
      write_csr(CSR_THRESHOLD, thr);
      write_csr(CSR_IMAGE_ROWS, rows);
      write_csr(CSR_IMAGE_COLS, cols);
      csr_we = 1'b0;
   endtask

   // mostly votes from pixels on a circle around a chosen center, then reads near it
   task automatic run_phase(int r, int thr, int rows, int cols, int n_items, bit quiet);
      int lim_r;
      int lim_c;
      int done;
      int cr;
      int cc;
      int dr;
      int dc;
      int sel;
      configure(r, thr, rows, cols);
      idle_on = !quiet;
      lim_r = (rows < 1 || rows > GRID) ? GRID : rows;
      lim_c = (cols < 1 || cols > GRID) ? GRID : cols;
      done = 0;
      while (done < n_items) begin
         sel = $urandom_range(99);
         if (sel < 60) begin
            cr = $urandom_range(lim_r - 1);
            cc = $urandom_range(lim_c - 1);
            repeat ($urandom_range(1, 6)) begin
               dr = 0;
               dc = 0;
               case ($urandom_range(3))
                  0: dr = r;
                  1: dr = -r;
                  2: dc = r;
                  default: dc = -r;
               endcase
               send_request(KIND_VOTE, PIX_W'(cr + dr), PIX_W'(cc + dc));
               done++;
            end
            repeat ($urandom_range(1, 3)) begin
               dr = int'($urandom_range(2)) - 1;
               dc = int'($urandom_range(2)) - 1;
               send_request(KIND_READ, PIX_W'(cr + dr), PIX_W'(cc + dc));
               done++;
            end
         end else if (sel < 85) begin
            send_request(KIND_VOTE, PIX_W'($urandom), PIX_W'($urandom));
            done++;
         end else begin
            send_request(KIND_READ, PIX_W'($urandom), PIX_W'($urandom));
            done++;
         end
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // defaults: radius 64, corners and center of the image
      send_request(KIND_READ, 8'd0, 8'd0);
      send_request(KIND_READ, 8'd255, 8'd255);
      send_request(KIND_VOTE, 8'd0, 8'd0);
      send_request(KIND_VOTE, 8'd255, 8'd255);
      send_request(KIND_VOTE, 8'd128, 8'd128);
      send_request(KIND_VOTE, 8'd128, 8'd128);
      send_request(KIND_READ, 8'd64, 8'd0);
      send_request(KIND_READ, 8'd0, 8'd64);
      send_request(KIND_READ, 8'd191, 8'd255);
      send_request(KIND_READ, 8'd128, 8'd192);
      send_request(KIND_READ, 8'd128, 8'd192);

      // radius 2 lands on x == y, so the diagonal cell gets two votes
      configure(2, 2, 256, 256);
      send_request(KIND_VOTE, 8'd50, 8'd50);
      send_request(KIND_READ, 8'd51, 8'd51);
      send_request(KIND_READ, 8'd52, 8'd50);
      send_request(KIND_READ, 8'd50, 8'd50);

      // radius zero votes four times into the pixel itself; threshold zero
      configure(0, 0, 256, 256);
      send_request(KIND_VOTE, 8'd10, 8'd10);
      send_request(KIND_READ, 8'd10, 8'd10);
      send_request(KIND_READ, 8'd11, 8'd10);

      // one-cell image; read outside the image but inside the store
      configure(1, 1, 1, 1);
      send_request(KIND_VOTE, 8'd0, 8'd1);
      send_request(KIND_READ, 8'd0, 8'd0);
      send_request(KIND_READ, 8'd1, 8'd1);

      // zero rows: nothing is in bounds
      configure(1, 1, 0, 256);
      send_request(KIND_VOTE, 8'd5, 8'd5);
      send_request(KIND_READ, 8'd5, 8'd6);

      // edge pixel outside the image still votes into it
      configure(5, 1, 10, 10);
      send_request(KIND_VOTE, 8'd14, 8'd3);
      send_request(KIND_READ, 8'd9, 8'd3);

      run_phase(1, 1, 256, 256, 200, 1'b0);
      run_phase(2, 2, 256, 256, 200, 1'b0);
      run_phase($urandom_range(3, 8), $urandom_range(4), $urandom_range(1, 256),
                $urandom_range(1, 256), 200, 1'b0);
      run_phase(5, 0, 1, 256, 100, 1'b0);
      run_phase($urandom_range(1, 20), 65535, 256, 1, 100, 1'b0);
      run_phase($urandom_range(9, 40), $urandom_range(3), 256, 256, 150, 1'b0);
      run_phase(127, 1, 256, 256, 40, 1'b0);
      run_phase($urandom_range(1, 12), $urandom_range(65535), $urandom_range(1, 256),
                $urandom_range(1, 256), 150, 1'b0);
      run_phase($urandom_range(1, 6), $urandom_range(5), 256, 256, 300, 1'b1);

      // pile votes into one cell, back to back, past the threshold
      configure(0, 200, 256, 256);
      idle_on = 1'b0;
      repeat (BURST_VOTES) send_request(KIND_VOTE, 8'd200, 8'd17);
      idle_on = 1'b1;
      send_request(KIND_READ, 8'd200, 8'd17);
      send_request(KIND_READ, 8'd200, 8'd18);

      settle();
      if (sb.failures == 0 && sb.pending_reads.size() == 0)
         $display("hough_circle_vote_fixed_radius verification clean");
      else
         $display("hough_circle_vote_fixed_radius verification failed");
      $finish;
   end

endmodule
